FILE: rtl/core/cct_pkg.sv
// Shared types, constants and parsing functions of the console command tokenizer.
package cct_pkg;

    // Limits of the tokenizer.
    localparam int MAX_TOKENS      = 64;
    localparam int MAX_TOKEN_CHARS = 1024;

    // Widths of the internal counters.
    localparam int LEN_W = $clog2(MAX_TOKEN_CHARS);
    localparam int CNT_W = $clog2(MAX_TOKENS + 1);

    // Widths of the result fields.
    localparam int KIND_W  = 2;
    localparam int TIDX_W  = 6;
    localparam int POS_W   = 10;
    localparam int CHAR_W  = 8;
    localparam int FOUND_W = 7;

    // At most this many results follow from one input byte.
    localparam int MAX_RES    = 5;
    localparam int RES_CNT_W  = $clog2(MAX_RES + 1);
    localparam int RES_IDX_W  = $clog2(MAX_RES);

    // Characters with a special meaning.
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        MODE_BETWEEN  = 2'd0,
        MODE_UNQUOTED = 2'd1,
        MODE_QUOTED   = 2'd2,
        MODE_IGNORE   = 2'd3
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        t_mode            mode;
        logic [CNT_W-1:0] total;
        logic [LEN_W-1:0] len;
        logic             held_slash;
        logic             held_backslash;
        logic             skip_quote;
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [TIDX_W-1:0]  token_index;
        logic [POS_W-1:0]   char_pos;
        logic [CHAR_W-1:0]  char_out;
        logic [FOUND_W-1:0] tokens_found;
    } t_result;

    // All results caused by one input byte.
    typedef struct packed {
        t_result [MAX_RES-1:0] res;
        logic [RES_CNT_W-1:0]  cnt;
    } t_bundle;

    typedef struct packed {
        t_state  st;
        t_bundle bd;
    } t_work;

    typedef struct packed {
        t_work w;
        logic  again;
    } t_step;

    localparam t_state STATE_RESET = '{
        mode:           MODE_BETWEEN,
        total:          '0,
        len:            '0,
        held_slash:     1'b0,
        held_backslash: 1'b0,
        skip_quote:     1'b0
    };

    function automatic logic is_space(logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Append one result; results beyond the bundle size are dropped.
    function automatic t_work emit(t_work w, t_kind k, logic [TIDX_W-1:0] idx,
                                   logic [POS_W-1:0] pos, logic [CHAR_W-1:0] ch,
                                   logic [FOUND_W-1:0] found);
        t_work   r;
        t_result e;
        r = w;
        e.kind         = k;
        e.token_index  = idx;
        e.char_pos     = pos;
        e.char_out     = ch;
        e.tokens_found = found;
        if (w.bd.cnt < RES_CNT_W'(MAX_RES)) begin
            r.bd.res[w.bd.cnt[RES_IDX_W-1:0]] = e;
            r.bd.cnt = w.bd.cnt + 1'b1;
        end
        return r;
    endfunction

    function automatic t_work close_token(t_work w);
        t_work r;
        r = emit(w, KIND_END, TIDX_W'(w.st.total - 1'b1), '0, '0, '0);
        r.st.len  = '0;
        r.st.mode = (w.st.total >= CNT_W'(MAX_TOKENS)) ? MODE_IGNORE : MODE_BETWEEN;
        return r;
    endfunction

    function automatic t_work open_token(t_work w, t_mode m);
        t_work r;
        r = w;
        r.st.total = w.st.total + 1'b1;
        r.st.len   = '0;
        r.st.mode  = m;
        return r;
    endfunction

    // Emit one token character and close the token when it reaches the cap.
    function automatic t_work emit_char(t_work w, logic [CHAR_W-1:0] c);
        t_work r;
        logic  quoted;
        quoted = (w.st.mode == MODE_QUOTED);
        r = emit(w, KIND_CHAR, TIDX_W'(w.st.total - 1'b1), POS_W'(w.st.len), c, '0);
        r.st.len = w.st.len + 1'b1;
        if (r.st.len >= LEN_W'(MAX_TOKEN_CHARS - 1)) begin
            r = close_token(r);
            r.st.skip_quote = quoted && (r.st.mode == MODE_BETWEEN);
        end
        return r;
    endfunction

    // One pass over a byte; again asks for a second pass with the same byte.
    function automatic t_step parse_step(t_work w, logic [CHAR_W-1:0] c);
        t_step s;
        logic  stop;
        s.w     = w;
        s.again = 1'b0;
        stop    = 1'b0;
        unique case (w.st.mode)
            MODE_BETWEEN: begin
                if (s.w.st.skip_quote) begin
                    s.w.st.skip_quote = 1'b0;
                    stop = (c == CH_QUOTE);
                end
                if (!stop) begin
                    if (s.w.st.held_slash) begin
                        s.w.st.held_slash = 1'b0;
                        if (c == CH_SLASH) begin
                            s.w.st.mode = MODE_IGNORE;
                        end else begin
                            s.w     = open_token(s.w, MODE_UNQUOTED);
                            s.w     = emit_char(s.w, CH_SLASH);
                            s.again = 1'b1;
                        end
                    end else if (c == CH_SLASH) begin
                        s.w.st.held_slash = 1'b1;
                    end else if (c == CH_QUOTE) begin
                        s.w = open_token(s.w, MODE_QUOTED);
                    end else if (!is_space(c)) begin
                        s.w = open_token(s.w, MODE_UNQUOTED);
                        s.w = emit_char(s.w, c);
                    end
                end
            end
            MODE_UNQUOTED: begin
                if (s.w.st.held_slash) begin
                    s.w.st.held_slash = 1'b0;
                    if (c == CH_SLASH) begin
                        s.w         = close_token(s.w);
                        s.w.st.mode = MODE_IGNORE;
                        stop        = 1'b1;
                    end else begin
                        s.w = emit_char(s.w, CH_SLASH);
                        if (s.w.st.mode != MODE_UNQUOTED) begin
                            s.again = 1'b1;
                            stop    = 1'b1;
                        end
                    end
                end
                if (!stop) begin
                    if (is_space(c)) begin
                        s.w = close_token(s.w);
                    end else if (c == CH_SLASH) begin
                        s.w.st.held_slash = 1'b1;
                    end else begin
                        s.w = emit_char(s.w, c);
                    end
                end
            end
            MODE_QUOTED: begin
                if (s.w.st.held_backslash) begin
                    s.w.st.held_backslash = 1'b0;
                    if ((c == CH_QUOTE) || (c == CH_BSLASH)) begin
                        s.w  = emit_char(s.w, c);
                        stop = 1'b1;
                    end else begin
                        s.w = emit_char(s.w, CH_BSLASH);
                        if (s.w.st.mode != MODE_QUOTED) begin
                            s.again = 1'b1;
                            stop    = 1'b1;
                        end
                    end
                end
                if (!stop) begin
                    if (c == CH_QUOTE) begin
                        s.w = close_token(s.w);
                    end else if (c == CH_BSLASH) begin
                        s.w.st.held_backslash = 1'b1;
                    end else begin
                        s.w = emit_char(s.w, c);
                    end
                end
            end
            MODE_IGNORE: begin
                s.again = 1'b0;
            end
            default: begin
                s.again = 1'b0;
            end
        endcase
        return s;
    endfunction

    // A byte needs at most two passes: the second one after a held character resolves.
    function automatic t_work process(t_work w, logic [CHAR_W-1:0] c);
        t_step a;
        t_step b;
        a = parse_step(w, c);
        b = parse_step(a.w, c);
        return a.again ? b.w : a.w;
    endfunction

    // End of text: resolve held characters and close the open token.
    function automatic t_work finish_text(t_work w);
        t_work r;
        r = w;
        if (r.st.held_slash) begin
            r.st.held_slash = 1'b0;
            if (r.st.mode == MODE_BETWEEN) begin
                r = open_token(r, MODE_UNQUOTED);
            end
            if (r.st.mode == MODE_UNQUOTED) begin
                r = emit_char(r, CH_SLASH);
            end
        end
        if (r.st.held_backslash) begin
            r.st.held_backslash = 1'b0;
            if (r.st.mode == MODE_QUOTED) begin
                r = emit_char(r, CH_BSLASH);
            end
        end
        if ((r.st.mode == MODE_UNQUOTED) || (r.st.mode == MODE_QUOTED)) begin
            r = close_token(r);
        end
        r.st.mode       = MODE_IGNORE;
        r.st.skip_quote = 1'b0;
        return r;
    endfunction

    // Whole effect of one input byte on the state, with its results.
    function automatic t_work item_work(t_state st, logic [CHAR_W-1:0] c, logic eol);
        t_work w;
        w.st = st;
        w.bd = '0;
        if (c == CH_NUL) begin
            w = finish_text(w);
        end else begin
            w = process(w, c);
        end
        if (eol) begin
            w    = finish_text(w);
            w    = emit(w, KIND_DONE, '0, '0, '0, FOUND_W'(w.st.total));
            w.st = STATE_RESET;
        end
        return w;
    endfunction

endpackage

FILE: rtl/core/cct_parser.sv
// Input register, parser state and per-byte result computation of the tokenizer.
module cct_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte_in,
    input  logic                i_end_of_line,
    output logic                o_bd_valid,
    output cct_pkg::t_bundle    o_bd,
    input  logic                i_bd_ready
);
    import cct_pkg::*;

    logic                r_in_valid;
    logic [CHAR_W-1:0]   r_byte;
    logic                r_eol;
    t_state              r_state;
    t_state              n_state;
    t_work               w_work;
    logic                w_adv;

    // The registered byte moves on once the result stage can take its bundle.
    assign w_adv   = r_in_valid && i_bd_ready;
    assign o_ready = !r_in_valid || i_bd_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte_in;
            r_eol  <= i_end_of_line;
        end
    end

    // Parse the registered byte against the current state.
    always_comb begin
        w_work = item_work(r_state, r_byte, r_eol);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        if (w_adv) begin
            n_state = w_work.st;
        end
    end

    // Outputs toward the result stage.
    always_comb begin
        o_bd_valid = r_in_valid;
        o_bd       = w_work.bd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // The token count never passes the limit.
    a_total_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.total <= CNT_W'(MAX_TOKENS))
        else $error("token count above limit");

    // A line end returns the parser to its reset state.
    a_eol_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_eol) |=> (r_state == STATE_RESET))
        else $error("state not cleared after line end");

    // A slash and a backslash are never held at once.
    a_held_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state.held_slash && r_state.held_backslash))
        else $error("slash and backslash held together");
`endif

endmodule

FILE: rtl/core/cct_drain.sv
// Result register that hands out the results of one byte, one per transfer.
module cct_drain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_bd_valid,
    input  cct_pkg::t_bundle              i_bd,
    output logic                          o_bd_ready,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cct_pkg::KIND_W-1:0]    o_kind,
    output logic [cct_pkg::TIDX_W-1:0]    o_token_index,
    output logic [cct_pkg::POS_W-1:0]     o_char_pos,
    output logic [cct_pkg::CHAR_W-1:0]    o_char_out,
    output logic [cct_pkg::FOUND_W-1:0]   o_tokens_found,
    output logic                          o_last_of_run
);
    import cct_pkg::*;

    logic                  r_bd_valid;
    t_bundle               r_bd;
    logic [RES_IDX_W-1:0]  r_pos;
    t_result               w_res;
    logic                  w_take;
    logic                  w_last;
    logic                  w_load;

    // Current result and the end of the run.
    assign w_res  = r_bd.res[r_pos];
    assign w_last = (RES_CNT_W'(r_pos) + 1'b1) == r_bd.cnt;
    assign w_take = r_bd_valid && i_ready;

    // A new bundle is taken once the last result of the old one leaves.
    assign o_bd_ready = !r_bd_valid || (w_take && w_last);
    assign w_load     = i_bd_valid && o_bd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bd_valid <= 1'b0;
            r_pos      <= '0;
        end else if (w_load) begin
            r_bd_valid <= (i_bd.cnt != '0);
            r_pos      <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_bd_valid <= 1'b0;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bd <= i_bd;
        end
    end

    // Output fields.
    assign o_valid        = r_bd_valid;
    assign o_kind         = w_res.kind;
    assign o_token_index  = w_res.token_index;
    assign o_char_pos     = w_res.char_pos;
    assign o_char_out     = w_res.char_out;
    assign o_tokens_found = w_res.tokens_found;
    assign o_last_of_run  = w_last;

`ifndef SYNTHESIS
    // A held bundle is never empty and the read position stays inside it.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bd_valid |-> ((r_bd.cnt != '0) && (RES_CNT_W'(r_pos) < r_bd.cnt)))
        else $error("result position outside bundle");

    // A transfer that is not the last of a run leaves more results waiting.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_last) |=> r_bd_valid)
        else $error("run ended early");

    // A result that waits for its transfer stays in place.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_pos) && $stable(r_bd)))
        else $error("waiting result changed");
`endif

endmodule

FILE: rtl/core/console_command_tokenizer_top.sv
// Top level of the console command tokenizer.
// The tokenizer takes one byte of a command line per transfer and returns token
// characters, token ends and a line-done count. A byte waits in the input
// register while its results are computed, then its results leave the result
// register one per cycle while the output is ready, so a byte with several
// results holds the input side until its last result leaves, and bytes with one
// result or none keep a rate of one byte per cycle while the output is ready.
// After reset no clearing pass is needed; the parser is ready at once.
module console_command_tokenizer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cct_pkg::CHAR_W-1:0]    i_byte_in,
    input  logic                          i_end_of_line,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cct_pkg::KIND_W-1:0]    o_kind,
    output logic [cct_pkg::TIDX_W-1:0]    o_token_index,
    output logic [cct_pkg::POS_W-1:0]     o_char_pos,
    output logic [cct_pkg::CHAR_W-1:0]    o_char_out,
    output logic [cct_pkg::FOUND_W-1:0]   o_tokens_found,
    output logic                          o_last_of_run
);
    import cct_pkg::*;

    logic     w_bd_valid;
    logic     w_bd_ready;
    t_bundle  w_bd;

    // Parser stage.
    cct_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_byte_in     (i_byte_in),
        .i_end_of_line (i_end_of_line),
        .o_bd_valid    (w_bd_valid),
        .o_bd          (w_bd),
        .i_bd_ready    (w_bd_ready)
    );

    // Result stage.
    cct_drain u_drain (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bd_valid     (w_bd_valid),
        .i_bd           (w_bd),
        .o_bd_ready     (w_bd_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_token_index  (o_token_index),
        .o_char_pos     (o_char_pos),
        .o_char_out     (o_char_out),
        .o_tokens_found (o_tokens_found),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

FILE: dv/tb_console_command_tokenizer_top.sv
// Self-checking testbench for the console command tokenizer top level.
`timescale 1ns / 1ps

module tb_console_command_tokenizer_top;
    import cct_pkg::*;

    localparam int CLK_HALF_NS  = 2;
    localparam int RANDOM_ITEMS = 90;
    localparam int QUIET_FROM   = 65;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SCRIPT_ROWS  = 27;

    // One result of the tokenizer, laid out like the result ports.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TIDX_W-1:0]  token_index;
        logic [POS_W-1:0]   char_pos;
        logic [CHAR_W-1:0]  char_out;
        logic [FOUND_W-1:0] tokens_found;
        logic               last_of_run;
    } t_token_event;

    // One row of the directed script; typed rows carry their single result.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eol;
        logic              typed;
        t_token_event      ev;
    } t_script_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [CHAR_W-1:0]    i_byte_in;
    logic                 i_end_of_line;
    logic                 o_valid;
    logic                 i_ready;
    logic [KIND_W-1:0]    o_kind;
    logic [TIDX_W-1:0]    o_token_index;
    logic [POS_W-1:0]     o_char_pos;
    logic [CHAR_W-1:0]    o_char_out;
    logic [FOUND_W-1:0]   o_tokens_found;
    logic                 o_last_of_run;

    // Parser state of the predictor.
    t_mode       tk_mode;
    int unsigned tk_count;
    int unsigned tk_len;
    bit          slash_wait;
    bit          bslash_wait;
    bit          quote_drop;

    t_token_event byte_events[$];
    t_token_event events_due[$];
    logic [CHAR_W-1:0] line_q[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int random_items   = 0;
    bit gaps_on;
    bit quiet;

    // Directed script: extremes, escapes, comments, held characters and the zero byte.
    t_script_row script_rows [SCRIPT_ROWS] = '{
        '{8'h0A, 1'b1, 1'b1, '{KIND_DONE, 6'd0, 10'd0, 8'h00, 7'd0, 1'b1}},
        '{8'hFF, 1'b0, 1'b1, '{KIND_CHAR, 6'd0, 10'd0, 8'hFF, 7'd0, 1'b1}},
        '{8'h01, 1'b0, 1'b0, '0},
        '{CH_TAB, 1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{8'h78, 1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_SLASH, 1'b0, 1'b0, '0},
        '{8'h61, 1'b0, 1'b0, '0},
        '{CH_SLASH, 1'b0, 1'b0, '0},
        '{CH_CR, 1'b0, 1'b0, '0},
        '{CH_SLASH, 1'b0, 1'b0, '0},
        '{CH_SLASH, 1'b0, 1'b0, '0},
        '{8'h7A, 1'b1, 1'b0, '0},
        '{CH_SLASH, 1'b1, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b1, 1'b0, '0},
        '{8'h71, 1'b0, 1'b0, '0},
        '{CH_NUL, 1'b0, 1'b0, '0},
        '{CH_NUL, 1'b1, 1'b1, '{KIND_DONE, 6'd0, 10'd0, 8'h00, 7'd1, 1'b1}}
    };

    console_command_tokenizer_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_byte_in      (i_byte_in),
        .i_end_of_line  (i_end_of_line),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_token_index  (o_token_index),
        .o_char_pos     (o_char_pos),
        .o_char_out     (o_char_out),
        .o_tokens_found (o_tokens_found),
        .o_last_of_run  (o_last_of_run)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #CLK_HALF_NS i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor of the token stream.
    // ------------------------------------------------------------------

    function automatic bit is_white(logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic void reset_parser();
        tk_mode     = MODE_BETWEEN;
        tk_count    = 0;
        tk_len      = 0;
        slash_wait  = 1'b0;
        bslash_wait = 1'b0;
        quote_drop  = 1'b0;
    endfunction

    // Results past the per-byte maximum are dropped, as the block does.
    function automatic void add_event(logic [KIND_W-1:0] k, int unsigned idx,
                                      int unsigned pos, logic [CHAR_W-1:0] c,
                                      int unsigned found);
        t_token_event ev;
        if (byte_events.size() >= MAX_RES) begin
            return;
        end
        ev.kind         = k;
        ev.token_index  = TIDX_W'(idx);
        ev.char_pos     = POS_W'(pos);
        ev.char_out     = c;
        ev.tokens_found = FOUND_W'(found);
        ev.last_of_run  = 1'b0;
        byte_events.push_back(ev);
    endfunction

    function automatic void end_token();
        add_event(KIND_END, tk_count - 1, 0, '0, 0);
        tk_len  = 0;
        tk_mode = (tk_count >= MAX_TOKENS) ? MODE_IGNORE : MODE_BETWEEN;
    endfunction

    function automatic void begin_token(t_mode m);
        tk_count++;
        tk_len  = 0;
        tk_mode = m;
    endfunction

    // A token that reaches the length cap closes; a capped quoted token drops one quote.
    function automatic void put_char(logic [CHAR_W-1:0] c);
        bit was_quoted;
        was_quoted = (tk_mode == MODE_QUOTED);
        add_event(KIND_CHAR, tk_count - 1, tk_len, c, 0);
        tk_len++;
        if (tk_len >= MAX_TOKEN_CHARS - 1) begin
            end_token();
            quote_drop = was_quoted && (tk_mode == MODE_BETWEEN);
        end
    endfunction

    // A byte is looked at again when a held slash opens a new token or a held character resolves into a closed token.
    function automatic void feed_char(logic [CHAR_W-1:0] c);
        bit again;
        bit settled;
        again = 1'b1;
        while (again) begin
            again   = 1'b0;
            settled = 1'b0;
            case (tk_mode)
                MODE_BETWEEN: begin
                    if (quote_drop) begin
                        quote_drop = 1'b0;
                        settled    = (c == CH_QUOTE);
                    end
                    if (!settled) begin
                        if (slash_wait) begin
                            slash_wait = 1'b0;
                            if (c == CH_SLASH) begin
                                tk_mode = MODE_IGNORE;
                            end else begin
                                begin_token(MODE_UNQUOTED);
                                put_char(CH_SLASH);
                                again = 1'b1;
                            end
                        end else if (c == CH_SLASH) begin
                            slash_wait = 1'b1;
                        end else if (c == CH_QUOTE) begin
                            begin_token(MODE_QUOTED);
                        end else if (!is_white(c)) begin
                            begin_token(MODE_UNQUOTED);
                            put_char(c);
                        end
                    end
                end
                MODE_UNQUOTED: begin
                    if (slash_wait) begin
                        slash_wait = 1'b0;
                        settled    = 1'b1;
                        if (c == CH_SLASH) begin
                            end_token();
                            tk_mode = MODE_IGNORE;
                        end else begin
                            put_char(CH_SLASH);
                            if (tk_mode != MODE_UNQUOTED) begin
                                again = 1'b1;
                            end else begin
                                settled = 1'b0;
                            end
                        end
                    end
                    if (!settled) begin
                        if (is_white(c)) begin
                            end_token();
                        end else if (c == CH_SLASH) begin
                            slash_wait = 1'b1;
                        end else begin
                            put_char(c);
                        end
                    end
                end
                MODE_QUOTED: begin
                    if (bslash_wait) begin
                        bslash_wait = 1'b0;
                        settled     = 1'b1;
                        if ((c == CH_QUOTE) || (c == CH_BSLASH)) begin
                            put_char(c);
                        end else begin
                            put_char(CH_BSLASH);
                            if (tk_mode != MODE_QUOTED) begin
                                again = 1'b1;
                            end else begin
                                settled = 1'b0;
                            end
                        end
                    end
                    if (!settled) begin
                        if (c == CH_QUOTE) begin
                            end_token();
                        end else if (c == CH_BSLASH) begin
                            bslash_wait = 1'b1;
                        end else begin
                            put_char(c);
                        end
                    end
                end
                default: begin
                    again = 1'b0;
                end
            endcase
        end
    endfunction

    // End of text resolves held characters and closes any open token.
    function automatic void end_text();
        if (slash_wait) begin
            slash_wait = 1'b0;
            if (tk_mode == MODE_BETWEEN) begin
                begin_token(MODE_UNQUOTED);
            end
            if (tk_mode == MODE_UNQUOTED) begin
                put_char(CH_SLASH);
            end
        end
        if (bslash_wait) begin
            bslash_wait = 1'b0;
            if (tk_mode == MODE_QUOTED) begin
                put_char(CH_BSLASH);
            end
        end
        if ((tk_mode == MODE_UNQUOTED) || (tk_mode == MODE_QUOTED)) begin
            end_token();
        end
        tk_mode    = MODE_IGNORE;
        quote_drop = 1'b0;
    endfunction

    // Works out every result that one input byte causes.
    function automatic void tokenize_byte(logic [CHAR_W-1:0] c, logic eol);
        t_token_event tail;
        byte_events.delete();
        if (c == CH_NUL) begin
            end_text();
        end else begin
            feed_char(c);
        end
        if (eol) begin
            end_text();
            add_event(KIND_DONE, 0, 0, '0, tk_count);
            reset_parser();
        end
        if (byte_events.size() > 0) begin
            tail = byte_events.pop_back();
            tail.last_of_run = 1'b1;
            byte_events.push_back(tail);
        end
    endfunction

    function automatic void book_events();
        foreach (byte_events[n]) begin
            events_due.push_back(byte_events[n]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Line builders for the random part.
    // ------------------------------------------------------------------

    function automatic logic [CHAR_W-1:0] plain_char();
        return CHAR_W'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [CHAR_W-1:0] blank_char();
        int unsigned r;
        r = $urandom_range(0, 9);
        return (r < 5) ? CHAR_W'(CH_TAB + r) : CH_SPACE;
    endfunction

    // Any non-blank, nonzero byte, leaning toward the characters with a meaning.
    function automatic logic [CHAR_W-1:0] word_char();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 9))
            0: c = CH_SLASH;
            1: c = CH_QUOTE;
            2: c = CH_BSLASH;
            default: begin
                do begin
                    c = CHAR_W'($urandom_range(1, 255));
                end while (is_white(c));
            end
        endcase
        return c;
    endfunction

    function automatic void add_word();
        repeat ($urandom_range(1, 6)) line_q.push_back(word_char());
    endfunction

    function automatic void add_quoted(bit closed);
        logic [CHAR_W-1:0] c;
        line_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 7))
                0: begin
                    line_q.push_back(CH_BSLASH);
                    case ($urandom_range(0, 2))
                        0: line_q.push_back(CH_QUOTE);
                        1: line_q.push_back(CH_BSLASH);
                        default: line_q.push_back(plain_char());
                    endcase
                end
                1: line_q.push_back(blank_char());
                default: begin
                    do begin
                        c = CHAR_W'($urandom_range(1, 255));
                    end while ((c == CH_QUOTE) || (c == CH_BSLASH));
                    line_q.push_back(c);
                end
            endcase
        end
        if (closed) begin
            line_q.push_back(CH_QUOTE);
        end else if ($urandom_range(0, 1) == 1) begin
            line_q.push_back(CH_BSLASH);
        end
    endfunction

    // A line of up to five tokens with random content; a quote may stay open.
    function automatic void build_token_line();
        int n_tok;
        line_q.delete();
        n_tok = $urandom_range(0, 5);
        for (int i = 0; i < n_tok; i++) begin
            repeat ($urandom_range((i > 0) ? 1 : 0, 2)) line_q.push_back(blank_char());
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_word();
                4, 5, 6: add_quoted(1'b1);
                7: add_quoted(1'b0);
                8: begin
                    line_q.push_back(CH_SLASH);
                    line_q.push_back(CH_SLASH);
                    add_word();
                end
                default: begin
                    add_word();
                    line_q.push_back(CH_SLASH);
                end
            endcase
        end
        if ($urandom_range(0, 9) == 0) begin
            line_q.push_back(CH_NUL);
            add_word();
        end
        if (line_q.size() == 0) begin
            line_q.push_back(blank_char());
        end
    endfunction

    // Random bytes, the zero byte among them.
    function automatic void build_noise_line();
        line_q.delete();
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 11))
                0: line_q.push_back(CH_NUL);
                1: line_q.push_back(CH_QUOTE);
                2: line_q.push_back(CH_SLASH);
                3: line_q.push_back(CH_BSLASH);
                4: line_q.push_back(CH_SPACE);
                default: line_q.push_back(CHAR_W'($urandom_range(1, 255)));
            endcase
        end
    endfunction

    function automatic void pick_gaps();
        gaps_on = !quiet && ($urandom_range(0, 3) != 0);
    endfunction

    // ------------------------------------------------------------------
    // Input side: one transfer per byte, with random gaps before it.
    // ------------------------------------------------------------------

    task automatic drive_byte(input logic [CHAR_W-1:0] c, input logic eol);
        if (gaps_on && ($urandom_range(0, 3) == 0)) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_byte_in     = c;
        i_end_of_line = eol;
        i_valid       = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eol);
        tokenize_byte(c, eol);
        book_events();
        drive_byte(c, eol);
    endtask

    task automatic send_line();
        foreach (line_q[n]) begin
            send_byte(line_q[n], n == line_q.size() - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall bursts on the result channel.
    // ------------------------------------------------------------------

    initial begin : ready_gen
        int stall_left;
        i_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_ready = 1'b0;
            end else if (gaps_on && ($urandom_range(0, 5) == 0)) begin
                stall_left = $urandom_range(0, 8);
                i_ready    = 1'b0;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    // Each result transfer is compared with the oldest expected event.
    always @(posedge i_clk) begin : check_results
        t_token_event want;
        if (i_rst_n && o_valid && i_ready) begin
            if (events_due.size() == 0) begin
                report_mismatch($sformatf("result of kind %0d with none expected", o_kind));
            end else begin
                want = events_due.pop_front();
                check_field("kind", o_kind, want.kind);
                check_field("token_index", o_token_index, want.token_index);
                check_field("char_pos", o_char_pos, want.char_pos);
                check_field("char_out", o_char_out, want.char_out);
                check_field("tokens_found", o_tokens_found, want.tokens_found);
                check_field("last_of_run", o_last_of_run, want.last_of_run);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** console_command_tokenizer_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_byte_in     = '0;
        i_end_of_line = 1'b0;
        quiet         = 1'b0;
        gaps_on       = 1'b0;
        reset_parser();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed script; typed rows carry their own expected result.
        gaps_on = 1'b1;
        foreach (script_rows[r]) begin
            tokenize_byte(script_rows[r].ch, script_rows[r].eol);
            if (script_rows[r].typed) begin
                byte_events.delete();
                byte_events.push_back(script_rows[r].ev);
            end
            book_events();
            drive_byte(script_rows[r].ch, script_rows[r].eol);
        end

        // Random lines; the last part runs without idle cycles.
        while (random_items < RANDOM_ITEMS) begin
            quiet = (random_items >= QUIET_FROM);
            pick_gaps();
            if ($urandom_range(0, 3) == 0) begin
                build_noise_line();
            end else begin
                build_token_line();
            end
            random_items += line_q.size();
            send_line();
        end
        i_valid = 1'b0;

        // Drain the remaining results, then allow for stray ones.
        while (events_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if ((mismatch_count == 0) && (events_due.size() == 0)) begin
            $display("** console_command_tokenizer_top: PASSED **");
        end else begin
            $display("** console_command_tokenizer_top: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/cct_pkg.sv
rtl/core/cct_parser.sv
rtl/core/cct_drain.sv
rtl/core/console_command_tokenizer_top.sv
dv/tb_console_command_tokenizer_top.sv
